>>> sv/hsom_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsom_pkg: shared types and constants of the sound output mixer
// Register indexes, reset values and the control structs passed between
// the register file, the per-side mixing logic and the top level.
// ----------------------------------------------------------------------------
package hsom_pkg;

    localparam int SMP_W      = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int BIAS_W     = 10;
    localparam int OUT_W      = 16;
    localparam int FIFO_VAL_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_NR50 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NR51 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CNTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS = 3'd3;

    localparam logic [7:0]        NR50_RST = 8'h77;
    localparam logic [7:0]        NR51_RST = 8'hFF;
    localparam logic [15:0]       CNTH_RST = 16'h210E;
    localparam logic [BIAS_W-1:0] BIAS_RST = 10'd512;

    typedef struct packed {
        logic [7:0]        nr50;
        logic [7:0]        nr51;
        logic [15:0]       cnth;
        logic [BIAS_W-1:0] bias;
    } t_cfg;

    // Controls of one output side.
    typedef struct packed {
        logic [3:0] pan;
        logic [2:0] vol;
        logic       a_on;
        logic       b_on;
    } t_side_cfg;

    typedef struct packed {
        logic [SMP_W-1:0]        square1_sample;
        logic [SMP_W-1:0]        square2_sample;
        logic [SMP_W-1:0]        wave_sample;
        logic [SMP_W-1:0]        noise_sample;
        logic signed [SMP_W-1:0] fifo_a_sample;
        logic signed [SMP_W-1:0] fifo_b_sample;
        logic                    block_end;
    } t_frame;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_out;
        logic signed [OUT_W-1:0] right_out;
        logic                    block_end_out;
    } t_result;

endpackage
`default_nettype wire

>>> sv/hsom_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsom_in_if / hsom_out_if: frame and result channels
// Valid/ready channels carrying one audio frame in and one stereo result out.
// ----------------------------------------------------------------------------
interface hsom_in_if;
    import hsom_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [SMP_W-1:0]        square1_sample;
    logic [SMP_W-1:0]        square2_sample;
    logic [SMP_W-1:0]        wave_sample;
    logic [SMP_W-1:0]        noise_sample;
    logic signed [SMP_W-1:0] fifo_a_sample;
    logic signed [SMP_W-1:0] fifo_b_sample;
    logic                    block_end;

    modport source (output valid, square1_sample, square2_sample, wave_sample,
                    noise_sample, fifo_a_sample, fifo_b_sample, block_end,
                    input ready);
    modport sink (input valid, square1_sample, square2_sample, wave_sample,
                  noise_sample, fifo_a_sample, fifo_b_sample, block_end,
                  output ready);
endinterface

interface hsom_out_if;
    import hsom_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;
    logic                    block_end_out;

    modport source (output valid, left_out, right_out, block_end_out,
                    input ready);
    modport sink (input valid, left_out, right_out, block_end_out,
                  output ready);
endinterface
`default_nettype wire

>>> sv/hsom_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsom_cfg_regs: mixer control registers
// Write-only register file holding master volume, pan masks, channel
// control and DAC bias. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module hsom_cfg_regs
    import hsom_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nr50 <= NR50_RST;
            r_cfg.nr51 <= NR51_RST;
            r_cfg.cnth <= CNTH_RST;
            r_cfg.bias <= BIAS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NR50: r_cfg.nr50 <= i_cfg_data[7:0];
                CFG_NR51: r_cfg.nr51 <= i_cfg_data[7:0];
                CFG_CNTH: r_cfg.cnth <= i_cfg_data;
                CFG_BIAS: r_cfg.bias <= i_cfg_data[BIAS_W-1:0];
                default:  ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> sv/hsom_mix_side.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsom_mix_side: one output side of the mixer
// Pans and sums the tone channels, applies master and tone volume, adds the
// sample channels, clamps around the DAC bias and scales to 16 bits.
// ----------------------------------------------------------------------------
module hsom_mix_side
    import hsom_pkg::*;
(
    input  t_frame                       i_frame,
    input  t_side_cfg                    i_side,
    input  wire [1:0]                    i_tone_code,
    input  wire [BIAS_W-1:0]             i_bias,
    input  wire signed [FIFO_VAL_W-1:0]  i_a_val,
    input  wire signed [FIFO_VAL_W-1:0]  i_b_val,
    output logic signed [OUT_W-1:0]      o_sample
);

    logic [9:0]         tone;
    logic [15:0]        tone_x8;
    logic [15:0]        vol_p1;
    logic [15:0]        boosted;
    logic [2:0]         shamt;
    logic [15:0]        shifted;
    logic signed [17:0] side;
    logic signed [17:0] level;
    logic [BIAS_W-1:0]  clamped;
    logic signed [16:0] diff;
    logic signed [16:0] scaled;

    always_comb begin
        tone = 10'd0;
        if (i_side.pan[0]) tone = tone + {2'b00, i_frame.square1_sample};
        if (i_side.pan[1]) tone = tone + {2'b00, i_frame.square2_sample};
        if (i_side.pan[2]) tone = tone + {2'b00, i_frame.wave_sample};
        if (i_side.pan[3]) tone = tone + {2'b00, i_frame.noise_sample};

        tone_x8 = {3'b000, tone, 3'b000};
        vol_p1  = {13'd0, i_side.vol} + 16'd1;
        boosted = tone_x8 * vol_p1;
        shamt   = 3'd4 - {1'b0, i_tone_code};
        shifted = boosted >> shamt;

        side = $signed({3'b000, shifted[14:0]});
        if (i_side.a_on) side = side + 18'(i_a_val);
        if (i_side.b_on) side = side + 18'(i_b_val);

        level = side + $signed({8'd0, i_bias});
        if (level[17]) begin
            clamped = '0;
        end else if (level >= 18'sd1024) begin
            clamped = '1;
        end else begin
            clamped = level[BIAS_W-1:0];
        end

        // Times 48 is a sum of two shifts.
        diff     = $signed({7'd0, clamped}) - $signed({7'd0, i_bias});
        scaled   = (diff <<< 5) + (diff <<< 4);
        o_sample = scaled[OUT_W-1:0];
    end

endmodule
`default_nettype wire

>>> sv/handheld_sound_output_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// handheld_sound_output_mixer: stereo output mixer with DAC bias
// Mixes four tone channels and two sample channels into a left and right
// 16-bit sample per frame.
// ----------------------------------------------------------------------------
// The mixer takes one frame per clock and returns one result per frame, in
// order: the frame lands in an input register and the full mix of both sides
// runs in one pass of logic into the result register. The rate of one frame
// per cycle is set by that single registered mixing pass. Back pressure on the
// output stalls the result register first and then the input register, so the
// input can still take one more frame while a finished result waits, and stops
// once both registers are full. Control registers are write-only and must be
// written while no frames are in flight.
module handheld_sound_output_mixer
    import hsom_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [CFG_DATA_W-1:0] i_cfg_data,
    hsom_in_if.sink              i_in,
    hsom_out_if.source           o_out
);

    t_cfg      cfg;
    t_side_cfg side_l;
    t_side_cfg side_r;

    t_frame    r_s1;
    t_frame    n_s1;
    logic      r_s1_valid;
    t_result   r_out;
    t_result   n_out;
    logic      r_out_valid;

    logic      s2_ready;
    logic      s1_adv;
    logic      in_ready;

    logic signed [FIFO_VAL_W-1:0] a_val;
    logic signed [FIFO_VAL_W-1:0] b_val;

    hsom_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign s2_ready = !r_out_valid || o_out.ready;
    assign s1_adv   = r_s1_valid && s2_ready;
    assign in_ready = !r_s1_valid || s2_ready;

    always_comb begin
        n_s1.square1_sample = i_in.square1_sample;
        n_s1.square2_sample = i_in.square2_sample;
        n_s1.wave_sample    = i_in.wave_sample;
        n_s1.noise_sample   = i_in.noise_sample;
        n_s1.fifo_a_sample  = i_in.fifo_a_sample;
        n_s1.fifo_b_sample  = i_in.fifo_b_sample;
        n_s1.block_end      = i_in.block_end;
    end

    always_comb begin
        side_l.pan  = cfg.nr51[7:4];
        side_l.vol  = cfg.nr50[6:4];
        side_l.a_on = cfg.cnth[9];
        side_l.b_on = cfg.cnth[13];
        side_r.pan  = cfg.nr51[3:0];
        side_r.vol  = cfg.nr50[2:0];
        side_r.a_on = cfg.cnth[8];
        side_r.b_on = cfg.cnth[12];
    end

    // Sample channels are doubled or quadrupled depending on their volume bit.
    assign a_val = cfg.cnth[2]
                 ? {r_s1.fifo_a_sample[7], r_s1.fifo_a_sample, 2'b00}
                 : {{2{r_s1.fifo_a_sample[7]}}, r_s1.fifo_a_sample, 1'b0};
    assign b_val = cfg.cnth[3]
                 ? {r_s1.fifo_b_sample[7], r_s1.fifo_b_sample, 2'b00}
                 : {{2{r_s1.fifo_b_sample[7]}}, r_s1.fifo_b_sample, 1'b0};

    hsom_mix_side u_left (
        .i_frame     (r_s1),
        .i_side      (side_l),
        .i_tone_code (cfg.cnth[1:0]),
        .i_bias      (cfg.bias),
        .i_a_val     (a_val),
        .i_b_val     (b_val),
        .o_sample    (n_out.left_out)
    );

    hsom_mix_side u_right (
        .i_frame     (r_s1),
        .i_side      (side_r),
        .i_tone_code (cfg.cnth[1:0]),
        .i_bias      (cfg.bias),
        .i_a_val     (a_val),
        .i_b_val     (b_val),
        .o_sample    (n_out.right_out)
    );

    assign n_out.block_end_out = r_s1.block_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_ready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.left_out      = r_out.left_out;
    assign o_out.right_out     = r_out.right_out;
    assign o_out.block_end_out = r_out.block_end_out;

    // A frame moving out of the input register must show up as a result.
    a_adv_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("frame lost between input and result register");

    // The end flag travels with its frame.
    a_end_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> (r_out.block_end_out == $past(r_s1.block_end)))
        else $error("block end flag not carried with its frame");

    // Input stalls only when both registers are full and the output is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s1_valid && r_out_valid && !o_out.ready))
        else $error("input stalled without a full pipeline");

    // A held frame keeps its contents while the result side is blocked.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s2_ready) |=> (r_s1_valid && $stable(r_s1)))
        else $error("input register changed while stalled");

endmodule
`default_nettype wire

>>> dv/tb_handheld_sound_output_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_handheld_sound_output_mixer: self-checking bench for the stereo mixer
// Drives audio frames through the valid/ready input channel, predicts each
// stereo result from a local model of the mix and its control registers, and
// checks every result in order.
// ----------------------------------------------------------------------------
module tb_handheld_sound_output_mixer;
    import hsom_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 4;
    localparam int DAC_MAX      = 1023;
    localparam int HOLD_CYCLES  = 400;
    localparam int BLOCK_ITEMS  = 32;

    // Indexes past the last register; writes to them must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    hsom_in_if  in_ch ();
    hsom_out_if out_ch ();

    t_cfg    mixer_cfg;
    t_result pending_mix[$];
    t_result want;
    int      mismatch_count = 0;
    int      stall_cycles   = 0;
    int      src_idle_pct   = 0;
    int      snk_idle_pct   = 0;
    int      hold_left      = 0;

    handheld_sound_output_mixer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Tone sum of one side, volume scaled, plus the enabled sample channels.
    function automatic int side_mix(input t_frame f, input logic [3:0] pan,
                                    input logic [2:0] vol, input int shift,
                                    input logic a_on, input logic b_on,
                                    input int a_val, input int b_val);
        int tone;
        int side;
        tone = 0;
        if (pan[0]) tone += int'(f.square1_sample);
        if (pan[1]) tone += int'(f.square2_sample);
        if (pan[2]) tone += int'(f.wave_sample);
        if (pan[3]) tone += int'(f.noise_sample);
        side = ((tone * 8) * (int'(vol) + 1)) >>> shift;
        if (a_on) side += a_val;
        if (b_on) side += b_val;
        return side;
    endfunction

    function automatic logic [OUT_W-1:0] side_finish(input int mixed,
                                                    input logic [BIAS_W-1:0] bias);
        int b;
        int level;
        int scaled;
        b     = int'(bias);
        level = mixed + b;
        if (level > DAC_MAX) level = DAC_MAX;
        else if (level < 0) level = 0;
        scaled = (level - b) * 48;
        return scaled[OUT_W-1:0];
    endfunction

    function automatic t_result mix_frame(input t_frame f, input t_cfg c);
        int      shift;
        int      a_val;
        int      b_val;
        t_result r;
        shift = 4 - int'(c.cnth[1:0]);
        a_val = $signed(f.fifo_a_sample);
        a_val = a_val * (c.cnth[2] ? 4 : 2);
        b_val = $signed(f.fifo_b_sample);
        b_val = b_val * (c.cnth[3] ? 4 : 2);
        r.left_out = side_finish(side_mix(f, c.nr51[7:4], c.nr50[6:4], shift,
                                          c.cnth[9], c.cnth[13], a_val, b_val),
                                 c.bias);
        r.right_out = side_finish(side_mix(f, c.nr51[3:0], c.nr50[2:0], shift,
                                           c.cnth[8], c.cnth[12], a_val, b_val),
                                  c.bias);
        r.block_end_out = f.block_end;
        return r;
    endfunction

    function automatic t_frame make_frame(input logic [7:0] s1, input logic [7:0] s2,
                                          input logic [7:0] wv, input logic [7:0] ns,
                                          input logic [7:0] fa, input logic [7:0] fb,
                                          input logic be);
        t_frame f;
        f.square1_sample = s1;
        f.square2_sample = s2;
        f.wave_sample    = wv;
        f.noise_sample   = ns;
        f.fifo_a_sample  = fa;
        f.fifo_b_sample  = fb;
        f.block_end      = be;
        return f;
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_fifo();
        case ($urandom_range(7))
            0: return 8'h80;
            1: return 8'h7F;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_frame rand_frame();
        return make_frame(pick_level(), pick_level(), pick_level(), pick_level(),
                          pick_fifo(), pick_fifo(), 1'($urandom_range(1)));
    endfunction

    // Scoreboard: check the result leaving, then predict the request taken,
    // then apply a register write, all from values sampled before the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mixer_cfg.nr50 = NR50_RST;
            mixer_cfg.nr51 = NR51_RST;
            mixer_cfg.cnth = CNTH_RST;
            mixer_cfg.bias = BIAS_RST;
            stall_cycles   = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (pending_mix.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with no request pending: L=%0d R=%0d E=%0b",
                             $time, out_ch.left_out, out_ch.right_out,
                             out_ch.block_end_out);
                end else begin
                    want = pending_mix.pop_front();
                    if (out_ch.left_out !== want.left_out) begin
                        mismatch_count++;
                        $display("%0t: left_out expected %0d actual %0d",
                                 $time, want.left_out, out_ch.left_out);
                    end
                    if (out_ch.right_out !== want.right_out) begin
                        mismatch_count++;
                        $display("%0t: right_out expected %0d actual %0d",
                                 $time, want.right_out, out_ch.right_out);
                    end
                    if (out_ch.block_end_out !== want.block_end_out) begin
                        mismatch_count++;
                        $display("%0t: block_end_out expected %0b actual %0b",
                                 $time, want.block_end_out, out_ch.block_end_out);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                pending_mix.push_back(mix_frame(make_frame(
                    in_ch.square1_sample, in_ch.square2_sample, in_ch.wave_sample,
                    in_ch.noise_sample, in_ch.fifo_a_sample, in_ch.fifo_b_sample,
                    in_ch.block_end), mixer_cfg));
            end
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_NR50: mixer_cfg.nr50 = cfg_data[7:0];
                    CFG_NR51: mixer_cfg.nr51 = cfg_data[7:0];
                    CFG_CNTH: mixer_cfg.cnth = cfg_data;
                    CFG_BIAS: mixer_cfg.bias = cfg_data[BIAS_W-1:0];
                    default: ;
                endcase
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (pending_mix.size() == 0 && !in_ch.valid)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
    end

    // Result side: random back pressure, or a long hold when one is asked for.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("tb_handheld_sound_output_mixer: done, errors");
        $finish;
    end

    // Valid stays high from one request to the next; it only drops on an
    // idle cycle or when the bench drains the block.
    task automatic send_frame(input t_frame f);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.square1_sample <= f.square1_sample;
        in_ch.square2_sample <= f.square2_sample;
        in_ch.wave_sample    <= f.wave_sample;
        in_ch.noise_sample   <= f.noise_sample;
        in_ch.fifo_a_sample  <= f.fifo_a_sample;
        in_ch.fifo_b_sample  <= f.fifo_b_sample;
        in_ch.block_end      <= f.block_end;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mixer(input logic [15:0] nr50, input logic [15:0] nr51,
                             input logic [15:0] cnth, input logic [15:0] bias);
        wait_idle();
        write_reg(CFG_NR50, nr50);
        write_reg(CFG_NR51, nr51);
        write_reg(CFG_CNTH, cnth);
        write_reg(CFG_BIAS, bias);
    endtask

    task automatic test_reset_values();
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_frame(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 1'b1));
        send_frame(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'h80, 1'b0));
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h7F, 1'b1));
        send_frame(make_frame(8'h11, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 1'b0));
        send_frame(make_frame(8'h00, 8'h22, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        send_frame(make_frame(8'h00, 8'h00, 8'h33, 8'h00, 8'h00, 8'h00, 1'b1));
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h44, 8'h00, 8'h00, 1'b0));
    endtask

    // Every tone volume code with split pan masks and volumes, so the two
    // sides differ; the last pass sets every bit that should have no effect.
    task automatic test_volume_codes();
        for (int code = 0; code < 4; code++) begin
            set_mixer(16'h0073, 16'h005A, 16'h3304 | 16'(code), 16'd512);
            send_frame(make_frame(8'd40, 8'd25, 8'd60, 8'd10, 8'hF0, 8'h21, 1'b0));
        end
        set_mixer(16'hFF8B, 16'hFFA5, 16'hCCF3, 16'hFC00 | 16'd512);
        send_frame(make_frame(8'd40, 8'd25, 8'd60, 8'd10, 8'hF0, 8'h21, 1'b1));
    endtask

    task automatic test_clamping();
        // Negative biased sum clamps to zero.
        set_mixer(16'h0000, 16'h0000, 16'h330C, 16'd0);
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'h80, 1'b0));
        // Sum well above full scale clamps to the top code.
        set_mixer(16'h0077, 16'h00FF, 16'h330F, 16'd1023);
        send_frame(make_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h7F, 1'b1));
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
        // One step past full scale.
        set_mixer(16'h0000, 16'h0000, 16'h3300, 16'd1000);
        send_frame(make_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'd6, 8'd6, 1'b0));
    endtask

    task automatic test_spare_index();
        logic [CFG_IDX_W-1:0] spare;
        wait_idle();
        for (int i = CFG_SPARE_FIRST; i <= CFG_SPARE_LAST; i++) begin
            spare = CFG_IDX_W'(i);
            write_reg(spare, 16'($urandom_range(16'hFFFF)));
        end
        send_frame(make_frame(8'd90, 8'd80, 8'd70, 8'd60, 8'hC0, 8'h40, 1'b1));
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 33; snk_idle_pct = 54; end
                1: begin src_idle_pct = 54; snk_idle_pct = 33; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int blk = 0; blk < 6; blk++) begin
                if (phase == 0 && blk == 0) begin
                    set_mixer(16'h0000, 16'h0000, 16'h0000, 16'h0000);
                end else if (phase == 0 && blk == 1) begin
                    set_mixer(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                end else begin
                    set_mixer(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                              16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)));
                end
                for (int n = 0; n < BLOCK_ITEMS; n++) send_frame(rand_frame());
            end
        end
    endtask

    // The result side holds off while requests keep coming, so the block
    // fills and stops taking requests.
    task automatic test_output_hold();
        src_idle_pct = 0;
        snk_idle_pct = 20;
        set_mixer(16'h0035, 16'h00C3, 16'h2107, 16'd300);
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        for (int n = 0; n < 30; n++) send_frame(rand_frame());
    endtask

    task automatic test_sender_pause();
        src_idle_pct = 33;
        snk_idle_pct = 54;
        for (int n = 0; n < 12; n++) send_frame(rand_frame());
        wait_idle();
        for (int n = 0; n < 12; n++) send_frame(rand_frame());
    endtask

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        in_ch.valid          = 1'b0;
        in_ch.square1_sample = '0;
        in_ch.square2_sample = '0;
        in_ch.wave_sample    = '0;
        in_ch.noise_sample   = '0;
        in_ch.fifo_a_sample  = '0;
        in_ch.fifo_b_sample  = '0;
        in_ch.block_end      = 1'b0;
        out_ch.ready         = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 33;
        snk_idle_pct = 54;
        test_reset_values();
        test_volume_codes();
        test_clamping();
        test_spare_index();
        test_random_phases();
        test_output_hold();
        test_sender_pause();

        wait_idle();
        if (mismatch_count == 0) begin
            $display("tb_handheld_sound_output_mixer: done, clean");
        end else begin
            $display("tb_handheld_sound_output_mixer: done, errors");
        end
        $finish;
    end

endmodule
